// ===== rtl/pwc_pkg.sv =====
// Package for the power window controller.
// Holds register reset values, register indexes, mode and jam step codes.
// No dependencies.
package pwc_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int CFG_BITS           = 16;
    localparam int CFG_ADDR_BITS      = 2;
    localparam int IN_BITS            = 8;
    localparam int OUT_BITS           = 8;

    localparam logic [CFG_BITS-1:0] SETTLE_RESET      = 16'd250;
    localparam logic [CFG_BITS-1:0] JAM_STOP_RESET    = 16'd50;
    localparam logic [CFG_BITS-1:0] JAM_REVERSE_RESET = 16'd500;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SETTLE      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_JAM_STOP    = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_JAM_REVERSE = 2'd2;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_SETTLE1 = 3'd1;
    localparam logic [2:0] MODE_SETTLE2 = 3'd2;
    localparam logic [2:0] MODE_MANUAL  = 3'd3;
    localparam logic [2:0] MODE_AUTO    = 3'd4;

    localparam logic [1:0] JSTEP_IDLE    = 2'd0;
    localparam logic [1:0] JSTEP_STOP1   = 2'd1;
    localparam logic [1:0] JSTEP_REVERSE = 2'd2;
    localparam logic [1:0] JSTEP_STOP2   = 2'd3;

endpackage

// ===== rtl/power_window_controller.sv =====
// Power window controller: one-touch movement with anti-pinch reversal.
// Depends on pwc_pkg.
//
// channel  dir  handshake         payload
// s_       in   s_tvalid/tready   s_tdata: one tick, eight button and event bits
// m_       out  m_tvalid/tready   m_tdata: motor and status bits
// cfg_     in   cfg_we            cfg_addr, cfg_wdata: timing registers
//
// Each tick beat passes the input register, one pass of state logic and the
// result register. A beat may be taken every cycle.
// An input beat reaches its result beat through the input and result registers.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled result register holds the input register, which then stalls s_.
module power_window_controller #(
    parameter int TIMER_BITS = pwc_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // driver_up, driver_down, passenger_up, passenger_down, window_lock,
    // upper_limit_hit, lower_limit_hit, jam_sensed
    input  logic [pwc_pkg::IN_BITS-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // motor_up, motor_down, auto_active, jam_recovery, four zero bits
    output logic [pwc_pkg::OUT_BITS-1:0]      m_tdata,
    input  logic                              cfg_we,
    input  logic [pwc_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [pwc_pkg::CFG_BITS-1:0]      cfg_wdata
);

    localparam int CMP_BITS = (TIMER_BITS > pwc_pkg::CFG_BITS) ? TIMER_BITS
                                                                : pwc_pkg::CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    function automatic logic [TIMER_BITS-1:0] timer_inc(input logic [TIMER_BITS-1:0] t);
        return (t == TMAX) ? t : t + TIMER_BITS'(1);
    endfunction

    function automatic logic timer_done(input logic [TIMER_BITS-1:0] t,
                                        input logic [pwc_pkg::CFG_BITS-1:0] len);
        logic [CMP_BITS-1:0] lim;
        logic [CMP_BITS-1:0] mx;
        mx  = CMP_BITS'(TMAX);
        lim = CMP_BITS'(len);
        if (lim > mx) begin
            lim = mx;
        end
        return CMP_BITS'(t) >= lim;
    endfunction

    logic [pwc_pkg::CFG_BITS-1:0] settle_reg, jam_stop_reg, jam_reverse_reg;

    logic                        in_valid_reg;
    logic [pwc_pkg::IN_BITS-1:0] in_data_reg;
    logic                        m_valid_reg;
    logic [3:0]                  m_data_reg;
    logic                        advance;

    logic [2:0]            mode_reg, mode_next;
    logic                  dir_reg, dir_next;
    logic                  src_reg, src_next;
    logic [TIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic                  at_upper_reg, at_upper_next;
    logic                  at_lower_reg, at_lower_next;
    logic                  jam_flag_reg, jam_flag_next;
    logic [1:0]            jstep_reg, jstep_next;
    logic [TIMER_BITS-1:0] jtimer_reg, jtimer_next;
    logic [3:0]            last_reg, last_next;
    logic [3:0]            out_next;

    logic [3:0]            buttons, edges;
    logic                  lock, up_hit, low_hit, jam, jam_new, held, target_clear;
    logic [1:0]            bit_sel;
    logic [pwc_pkg::CFG_BITS-1:0] jlen;
    logic                  m_up, m_down;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg      <= pwc_pkg::SETTLE_RESET;
            jam_stop_reg    <= pwc_pkg::JAM_STOP_RESET;
            jam_reverse_reg <= pwc_pkg::JAM_REVERSE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pwc_pkg::CFG_SETTLE:      settle_reg      <= cfg_wdata;
                pwc_pkg::CFG_JAM_STOP:    jam_stop_reg    <= cfg_wdata;
                pwc_pkg::CFG_JAM_REVERSE: jam_reverse_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        buttons = in_data_reg[3:0];
        lock    = in_data_reg[4];
        up_hit  = in_data_reg[5];
        low_hit = in_data_reg[6];
        jam     = in_data_reg[7];

        mode_next     = mode_reg;
        dir_next      = dir_reg;
        src_next      = src_reg;
        ptimer_next   = ptimer_reg;
        at_upper_next = at_upper_reg;
        at_lower_next = at_lower_reg;
        jam_flag_next = jam_flag_reg;
        jstep_next    = jstep_reg;
        jtimer_next   = jtimer_reg;
        jam_new       = 1'b0;

        if (up_hit) begin
            at_upper_next = 1'b1;
            at_lower_next = 1'b0;
            if (mode_next == pwc_pkg::MODE_MANUAL || mode_next == pwc_pkg::MODE_AUTO) begin
                mode_next = pwc_pkg::MODE_IDLE;
            end
        end
        if (low_hit) begin
            at_lower_next = 1'b1;
            at_upper_next = 1'b0;
            if (mode_next == pwc_pkg::MODE_MANUAL || mode_next == pwc_pkg::MODE_AUTO) begin
                mode_next = pwc_pkg::MODE_IDLE;
            end
        end

        jlen = (jstep_reg == pwc_pkg::JSTEP_REVERSE) ? jam_reverse_reg : jam_stop_reg;
        if (jam && !jam_flag_reg) begin
            jam_flag_next = 1'b1;
            jstep_next    = pwc_pkg::JSTEP_STOP1;
            jtimer_next   = '0;
            mode_next     = pwc_pkg::MODE_IDLE;
            jam_new       = 1'b1;
        end else if (jstep_reg != pwc_pkg::JSTEP_IDLE) begin
            jtimer_next = timer_inc(jtimer_reg);
            if (timer_done(jtimer_next, jlen)) begin
                jtimer_next = '0;
                jstep_next  = (jstep_reg == pwc_pkg::JSTEP_STOP2) ? pwc_pkg::JSTEP_IDLE
                                                                   : jstep_reg + 2'd1;
            end
        end

        bit_sel = {src_reg, ~dir_reg};
        held    = buttons[bit_sel];

        unique case (mode_next)
            pwc_pkg::MODE_IDLE: begin
            end
            pwc_pkg::MODE_SETTLE1: begin
                ptimer_next = timer_inc(ptimer_reg);
                if (timer_done(ptimer_next, settle_reg)) begin
                    ptimer_next = '0;
                    if (dir_reg) begin
                        at_lower_next = 1'b0;
                    end else begin
                        at_upper_next = 1'b0;
                    end
                    jam_flag_next = 1'b0;
                    mode_next = held ? pwc_pkg::MODE_SETTLE2 : pwc_pkg::MODE_IDLE;
                end
            end
            pwc_pkg::MODE_SETTLE2: begin
                ptimer_next = timer_inc(ptimer_reg);
                if (timer_done(ptimer_next, settle_reg)) begin
                    ptimer_next = '0;
                    if (dir_reg ? at_upper_next : at_lower_next) begin
                        mode_next = pwc_pkg::MODE_IDLE;
                    end else begin
                        mode_next = held ? pwc_pkg::MODE_MANUAL : pwc_pkg::MODE_AUTO;
                    end
                end
            end
            pwc_pkg::MODE_MANUAL: begin
                if (!held || (dir_reg ? at_upper_next : at_lower_next) ||
                    (dir_reg && jam_flag_next)) begin
                    mode_next = pwc_pkg::MODE_IDLE;
                end
            end
            pwc_pkg::MODE_AUTO: begin
            end
            default: begin
                mode_next = pwc_pkg::MODE_IDLE;
            end
        endcase

        edges = buttons & ~last_reg;
        if (lock) begin
            edges[3:2] = 2'b00;
        end
        if (mode_next == pwc_pkg::MODE_IDLE && jstep_next == pwc_pkg::JSTEP_IDLE &&
            !jam_new && edges != 4'b0000) begin
            ptimer_next = '0;
            mode_next   = pwc_pkg::MODE_SETTLE1;
            if (edges[0]) begin
                src_next = 1'b0;
                dir_next = 1'b1;
            end else if (edges[1]) begin
                src_next = 1'b0;
                dir_next = 1'b0;
            end else if (edges[2]) begin
                src_next = 1'b1;
                dir_next = 1'b1;
            end else begin
                src_next = 1'b1;
                dir_next = 1'b0;
            end
        end
        last_next = buttons;

        target_clear = ~at_lower_next;
        m_up   = 1'b0;
        m_down = 1'b0;
        if (jstep_next == pwc_pkg::JSTEP_REVERSE) begin
            m_down = target_clear;
        end else if (jstep_next == pwc_pkg::JSTEP_IDLE &&
                     (mode_next == pwc_pkg::MODE_MANUAL || mode_next == pwc_pkg::MODE_AUTO)) begin
            m_up   = dir_next;
            m_down = ~dir_next;
        end
        out_next = {jstep_next != pwc_pkg::JSTEP_IDLE, mode_next == pwc_pkg::MODE_AUTO,
                    m_down, m_up};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            mode_reg     <= pwc_pkg::MODE_IDLE;
            dir_reg      <= 1'b0;
            src_reg      <= 1'b0;
            ptimer_reg   <= '0;
            at_upper_reg <= 1'b0;
            at_lower_reg <= 1'b0;
            jam_flag_reg <= 1'b0;
            jstep_reg    <= pwc_pkg::JSTEP_IDLE;
            jtimer_reg   <= '0;
            last_reg     <= 4'b0000;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg  <= 1'b1;
                mode_reg     <= mode_next;
                dir_reg      <= dir_next;
                src_reg      <= src_next;
                ptimer_reg   <= ptimer_next;
                at_upper_reg <= at_upper_next;
                at_lower_reg <= at_lower_next;
                jam_flag_reg <= jam_flag_next;
                jstep_reg    <= jstep_next;
                jtimer_reg   <= jtimer_next;
                last_reg     <= last_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            m_data_reg <= out_next;
        end
    end

endmodule

// ===== rtl/pwc_checker.sv =====
// Port-level checks for the power window controller, bound to the top level.
// Depends on pwc_pkg for widths only.
module pwc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pwc_pkg::OUT_BITS-1:0]      m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_motor_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("motor driven both ways");

    a_auto_jam: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[3] && (m_tdata[0] || m_tdata[1]))
        else $error("auto run without motor or during jam recovery");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'b0000)
        else $error("padding bits set");

endmodule

bind power_window_controller pwc_checker u_pwc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
